// ----- design/robb_pkg.sv -----
// Shared constants and types for the ray versus oriented box hit test.
`default_nettype none

package robb_pkg;

   localparam int DEF_COORD_WIDTH = 16;
   localparam int DIR_WIDTH       = 16;
   localparam int DIR_FRAC_BITS   = 14;
   localparam int REG_WIDTH       = 48;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_CENTER     = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_AXIS_U     = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_AXIS_V     = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_AXIS_W     = CSR_INDEX_WIDTH'(3);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_HALF_SIZES = CSR_INDEX_WIDTH'(4);

   // Raw register images of the box; axis[0..2] are u, v and w.
   typedef struct packed {
      logic [REG_WIDTH-1:0]        center;
      logic [2:0][REG_WIDTH-1:0]   axis;
      logic [REG_WIDTH-1:0]        half_sizes;
   } box_type;

   typedef struct packed {
      logic advance;
      logic take;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

// ----- design/robb_if.sv -----
// Handshake channel interfaces for requests, responses and register writes.
`default_nettype none

interface robb_req_if #(parameter int COORD_WIDTH = robb_pkg::DEF_COORD_WIDTH);
   logic                                 valid;
   logic                                 ready;
   logic signed [COORD_WIDTH-1:0]        origin_x;
   logic signed [COORD_WIDTH-1:0]        origin_y;
   logic signed [COORD_WIDTH-1:0]        origin_z;
   logic signed [robb_pkg::DIR_WIDTH-1:0] dir_x;
   logic signed [robb_pkg::DIR_WIDTH-1:0] dir_y;
   logic signed [robb_pkg::DIR_WIDTH-1:0] dir_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

interface robb_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

interface robb_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [robb_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [robb_pkg::REG_WIDTH-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/robb_pipe.sv -----
// Six-stage exact fixed-point pipeline for the separating-axis ray/box test.
`default_nettype none

module robb_pipe #(
   parameter int COORD_WIDTH = robb_pkg::DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  robb_pkg::pipe_ctrl_type       ctrl,
   input  logic signed [COORD_WIDTH-1:0] org [3],
   input  logic signed [robb_pkg::DIR_WIDTH-1:0] dir [3],
   input  robb_pkg::box_type             box,
   output logic                          out_valid,
   output logic                          out_hit
);

   localparam int CW         = COORD_WIDTH;
   localparam int DW         = robb_pkg::DIR_WIDTH;
   localparam int FIELD_SPAN = (3 * CW > robb_pkg::REG_WIDTH) ? 3 * CW : robb_pkg::REG_WIDTH;
   localparam int DIFF_W     = CW + 1;
   localparam int PDD_W      = 2 * DW;
   localparam int WDU_W      = 2 * DW + 1;
   localparam int AWDU_W     = 2 * DW;
   localparam int PDA_W      = DIFF_W + DW;
   localparam int DDU_W      = PDA_W + 2;
   localparam int PCX_W      = DW + DIFF_W;
   localparam int CX_W       = PCX_W + 1;
   localparam int PLX_W      = CX_W + DW;
   localparam int LHS_W      = PLX_W + 2;
   localparam int PRX_W      = CW + AWDU_W;
   localparam int RHS_W      = PRX_W + 1;
   localparam int CMP_W      = LHS_W + 1;

   // Register fields; bits of a position field beyond the register read as zero.
   logic [FIELD_SPAN-1:0]    cen_span;
   logic [FIELD_SPAN-1:0]    half_span;
   logic signed [CW-1:0]     cen [3];
   logic [CW-1:0]            half [3];
   logic signed [DW-1:0]     ax [3][3];

   assign cen_span  = FIELD_SPAN'(box.center);
   assign half_span = FIELD_SPAN'(box.half_sizes);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cen[i]  = cen_span[i*CW +: CW];
         half[i] = half_span[i*CW +: CW];
         for (int k = 0; k < 3; k++) begin
            ax[k][i] = box.axis[k][i*DW +: DW];
         end
      end
   end

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff, f_valid_ff;

   logic signed [DIFF_W-1:0] a_diff_ff [3];
   logic signed [DW-1:0]     a_dir_ff [3];
   logic signed [PDD_W-1:0]  a_pdd_ff [3][3];

   logic signed [WDU_W-1:0]  b_wdu_ff [3];
   logic signed [PDA_W-1:0]  b_pda_ff [3][3];
   logic signed [PCX_W-1:0]  b_pcx_pos_ff [3];
   logic signed [PCX_W-1:0]  b_pcx_neg_ff [3];

   logic signed [DDU_W-1:0]  c_ddu_ff [3];
   logic signed [CX_W-1:0]   c_cx_ff [3];
   logic [AWDU_W-1:0]        c_awdu_ff [3];
   logic [2:0]               c_wneg_ff;
   logic [2:0]               c_wzero_ff;

   logic                     d_face_ok_ff;
   logic signed [PLX_W-1:0]  d_plx_ff [3][3];
   logic [PRX_W-1:0]         d_prx_ff [3][2];

   logic                     e_face_ok_ff;
   logic signed [LHS_W-1:0]  e_lhs_ff [3];
   logic [RHS_W-1:0]         e_rhs_ff [3];

   logic                     f_hit_ff;

   // Face-axis slab test.
   logic signed [DDU_W-1:0]  face_lim [3];
   logic signed [DDU_W-1:0]  face_low [3];
   logic [2:0]               face_sep;
   logic                     d_face_ok_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         face_lim[k] = DDU_W'({half[k], {robb_pkg::DIR_FRAC_BITS{1'b0}}});
         face_low[k] = c_ddu_ff[k] + face_lim[k];
         // Outside the slab and the direction does not point back toward the box.
         face_sep[k] = ((c_ddu_ff[k] > face_lim[k]) || face_low[k][DDU_W-1]) &&
                       (c_wzero_ff[k] || (c_ddu_ff[k][DDU_W-1] == c_wneg_ff[k]));
      end
      d_face_ok_in = ~|face_sep;
   end

   // Cross-axis test: |lhs| > rhs means the axis separates.
   logic signed [CMP_W-1:0]  cmp_lhs [3];
   logic signed [CMP_W-1:0]  cmp_rhs [3];
   logic signed [CMP_W-1:0]  cmp_sum [3];
   logic [2:0]               cross_sep;
   logic                     f_hit_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cmp_lhs[k]   = CMP_W'(e_lhs_ff[k]);
         cmp_rhs[k]   = CMP_W'(e_rhs_ff[k]);
         cmp_sum[k]   = cmp_lhs[k] + cmp_rhs[k];
         cross_sep[k] = (cmp_lhs[k] > cmp_rhs[k]) || cmp_sum[k][CMP_W-1];
      end
      f_hit_in = e_face_ok_ff && ~|cross_sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         a_valid_ff <= ctrl.take;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         // Stage A: offset from the centre, products of the direction and axis components.
         for (int i = 0; i < 3; i++) begin
            a_diff_ff[i] <= {org[i][CW-1], org[i]} - {cen[i][CW-1], cen[i]};
            a_dir_ff[i]  <= dir[i];
            for (int k = 0; k < 3; k++) begin
               a_pdd_ff[k][i] <= PDD_W'(dir[i]) * PDD_W'(ax[k][i]);
            end
         end

         // Stage B: direction projections, offset products, cross products.
         for (int k = 0; k < 3; k++) begin
            b_wdu_ff[k] <= WDU_W'(a_pdd_ff[k][0]) + WDU_W'(a_pdd_ff[k][1]) +
                           WDU_W'(a_pdd_ff[k][2]);
            for (int i = 0; i < 3; i++) begin
               b_pda_ff[k][i] <= PDA_W'(a_diff_ff[i]) * PDA_W'(ax[k][i]);
            end
         end
         b_pcx_pos_ff[0] <= PCX_W'(a_dir_ff[1]) * PCX_W'(a_diff_ff[2]);
         b_pcx_neg_ff[0] <= PCX_W'(a_dir_ff[2]) * PCX_W'(a_diff_ff[1]);
         b_pcx_pos_ff[1] <= PCX_W'(a_dir_ff[2]) * PCX_W'(a_diff_ff[0]);
         b_pcx_neg_ff[1] <= PCX_W'(a_dir_ff[0]) * PCX_W'(a_diff_ff[2]);
         b_pcx_pos_ff[2] <= PCX_W'(a_dir_ff[0]) * PCX_W'(a_diff_ff[1]);
         b_pcx_neg_ff[2] <= PCX_W'(a_dir_ff[1]) * PCX_W'(a_diff_ff[0]);

         // Stage C: offset projections, cross vector, projection magnitudes.
         for (int k = 0; k < 3; k++) begin
            c_ddu_ff[k]   <= DDU_W'(b_pda_ff[k][0]) + DDU_W'(b_pda_ff[k][1]) +
                             DDU_W'(b_pda_ff[k][2]);
            c_cx_ff[k]    <= CX_W'(b_pcx_pos_ff[k]) - CX_W'(b_pcx_neg_ff[k]);
            c_awdu_ff[k]  <= b_wdu_ff[k][WDU_W-1] ? AWDU_W'(-b_wdu_ff[k])
                                                  : AWDU_W'(b_wdu_ff[k]);
            c_wneg_ff[k]  <= b_wdu_ff[k][WDU_W-1];
            c_wzero_ff[k] <= (b_wdu_ff[k] == '0);
         end

         // Stage D: face verdict, products for the cross-axis sides.
         d_face_ok_ff <= d_face_ok_in;
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               d_plx_ff[k][i] <= PLX_W'(c_cx_ff[i]) * PLX_W'(ax[k][i]);
            end
         end
         d_prx_ff[0][0] <= PRX_W'(half[1]) * PRX_W'(c_awdu_ff[2]);
         d_prx_ff[0][1] <= PRX_W'(half[2]) * PRX_W'(c_awdu_ff[1]);
         d_prx_ff[1][0] <= PRX_W'(half[0]) * PRX_W'(c_awdu_ff[2]);
         d_prx_ff[1][1] <= PRX_W'(half[2]) * PRX_W'(c_awdu_ff[0]);
         d_prx_ff[2][0] <= PRX_W'(half[0]) * PRX_W'(c_awdu_ff[1]);
         d_prx_ff[2][1] <= PRX_W'(half[1]) * PRX_W'(c_awdu_ff[0]);

         // Stage E: both sides of each cross-axis comparison.
         e_face_ok_ff <= d_face_ok_ff;
         for (int k = 0; k < 3; k++) begin
            e_lhs_ff[k] <= LHS_W'(d_plx_ff[k][0]) + LHS_W'(d_plx_ff[k][1]) +
                           LHS_W'(d_plx_ff[k][2]);
            e_rhs_ff[k] <= RHS_W'(d_prx_ff[k][0]) + RHS_W'(d_prx_ff[k][1]);
         end

         // Stage F: output register.
         f_hit_ff <= f_hit_in;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_hit   = f_hit_ff;

endmodule

`default_nettype wire

// ----- design/ray_obb_overlap_test_top.sv -----
// Top level of the ray versus oriented box hit test: box registers and pipeline.
//
//   Channel   Direction  Contents
//   req_chan  in         ray origin x/y/z (signed position), direction x/y/z (Q1.14)
//   rsp_chan  out        hit flag, one response per request
//   csr_chan  in         register index and 48-bit data for the box registers
//
// One request enters every cycle while the sink takes responses; its response comes
// out of the six register stages of the datapath (A through F, F being the output register).
// Reset clears the pipeline valid bits and all box registers to zero.
// When the response is held by the sink, every stage holds and req_chan.ready drops.
// Register writes are always accepted; writes to an unused index are dropped.
`default_nettype none

module ray_obb_overlap_test_top #(
   parameter int COORD_WIDTH = robb_pkg::DEF_COORD_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   robb_req_if.sink   req_chan,
   robb_rsp_if.source rsp_chan,
   robb_csr_if.sink   csr_chan
);

   robb_pkg::box_type       box_ff;
   robb_pkg::pipe_ctrl_type ctrl;
   logic signed [COORD_WIDTH-1:0]        org [3];
   logic signed [robb_pkg::DIR_WIDTH-1:0] dir [3];
   logic                    out_valid;
   logic                    out_hit;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            robb_pkg::CSR_BOX_CENTER:     box_ff.center     <= csr_chan.data;
            robb_pkg::CSR_BOX_AXIS_U:     box_ff.axis[0]    <= csr_chan.data;
            robb_pkg::CSR_BOX_AXIS_V:     box_ff.axis[1]    <= csr_chan.data;
            robb_pkg::CSR_BOX_AXIS_W:     box_ff.axis[2]    <= csr_chan.data;
            robb_pkg::CSR_BOX_HALF_SIZES: box_ff.half_sizes <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves whenever the output register is empty or being drained.
   assign ctrl.advance   = !out_valid || rsp_chan.ready;
   assign ctrl.take      = req_chan.valid;
   assign req_chan.ready = ctrl.advance;

   assign org[0] = req_chan.origin_x;
   assign org[1] = req_chan.origin_y;
   assign org[2] = req_chan.origin_z;
   assign dir[0] = req_chan.dir_x;
   assign dir[1] = req_chan.dir_y;
   assign dir[2] = req_chan.dir_z;

   robb_pipe #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .org       (org),
      .dir       (dir),
      .box       (box_ff),
      .out_valid (out_valid),
      .out_hit   (out_hit)
   );

   assign rsp_chan.valid = out_valid;
   assign rsp_chan.hit   = out_hit;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the ray versus oriented box hit test.
module tb;

   localparam int CW         = robb_pkg::DEF_COORD_WIDTH;
   localparam int DW         = robb_pkg::DIR_WIDTH;
   localparam int RW         = robb_pkg::REG_WIDTH;
   localparam int IW         = robb_pkg::CSR_INDEX_WIDTH;
   localparam int DIR_ONE    = 1 << robb_pkg::DIR_FRAC_BITS;
   localparam int POS_ONE    = 256;
   localparam int DIAG       = 11585;
   localparam int DRAIN_GAP  = 8;
   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic signed [CW-1:0] origin [3];
      logic signed [DW-1:0] dir [3];
   } ray_type;

   logic clock;
   logic reset;

   robb_req_if req_chan ();
   robb_rsp_if rsp_chan ();
   robb_csr_if csr_chan ();

   ray_obb_overlap_test_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   robb_pkg::box_type box_regs;
   bit      hit_expected [$];
   int      fail_count;
   bit      steady_flow;
   int      rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint mag_of(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic bit ray_meets_box(input ray_type r);
      longint org_off [3];
      longint dir [3];
      longint ext [3];
      longint ax [3][3];
      longint face_dir [3];
      longint face_off [3];
      longint cx [3];
      longint lhs;
      longint rhs;
      int     a;
      int     b;
      bit     hit;
      hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         dir[i]     = r.dir[i];
         org_off[i] = longint'(r.origin[i]) - longint'($signed(box_regs.center[CW*i +: CW]));
         ext[i]     = longint'(box_regs.half_sizes[CW*i +: CW]);
         for (int k = 0; k < 3; k++)
            ax[k][i] = $signed(box_regs.axis[k][DW*i +: DW]);
      end
      for (int k = 0; k < 3; k++) begin
         face_dir[k] = dir[0] * ax[k][0] + dir[1] * ax[k][1] + dir[2] * ax[k][2];
         face_off[k] = org_off[0] * ax[k][0] + org_off[1] * ax[k][1] + org_off[2] * ax[k][2];
         // Outside the slab and not heading back into it; a zero product never approaches.
         if (mag_of(face_off[k]) > ext[k] * DIR_ONE &&
             (face_off[k] == 0 || face_dir[k] == 0 || (face_off[k] < 0) == (face_dir[k] < 0)))
            hit = 1'b0;
      end
      cx[0] = dir[1] * org_off[2] - dir[2] * org_off[1];
      cx[1] = dir[2] * org_off[0] - dir[0] * org_off[2];
      cx[2] = dir[0] * org_off[1] - dir[1] * org_off[0];
      for (int k = 0; k < 3; k++) begin
         // The box radius on the axis dir x axis_k comes from the two other face axes.
         a   = (k == 0) ? 1 : 0;
         b   = (k == 2) ? 1 : 2;
         lhs = cx[0] * ax[k][0] + cx[1] * ax[k][1] + cx[2] * ax[k][2];
         rhs = ext[a] * mag_of(face_dir[b]) + ext[b] * mag_of(face_dir[a]);
         if (mag_of(lhs) > rhs)
            hit = 1'b0;
      end
      return hit;
   endfunction

   function automatic logic [RW-1:0] pack3(input int x, input int y, input int z);
      return {CW'(z), CW'(y), CW'(x)};
   endfunction

   function automatic ray_type make_ray(input int ox, input int oy, input int oz,
                                        input int dx, input int dy, input int dz);
      ray_type r;
      r.origin = '{CW'(ox), CW'(oy), CW'(oz)};
      r.dir    = '{DW'(dx), DW'(dy), DW'(dz)};
      return r;
   endfunction

   // Mostly origins scattered around the box centre, some aimed back at it.
   function automatic ray_type random_ray();
      ray_type              r;
      logic signed [CW-1:0] cen;
      int                   span;
      bit                   near;
      bit                   aim;
      near = $urandom_range(0, 9) < 7;
      aim  = near && ($urandom_range(0, 3) == 0);
      span = $urandom_range(0, 4096);
      for (int i = 0; i < 3; i++) begin
         cen = box_regs.center[CW*i +: CW];
         if (near)
            r.origin[i] = cen + CW'($urandom_range(0, 2 * span)) - CW'(span);
         else
            r.origin[i] = CW'($urandom);
         if (aim)
            r.dir[i] = DW'((cen - r.origin[i]) <<< 2);
         else if ($urandom_range(0, 7) == 0)
            r.dir[i] = '0;
         else
            r.dir[i] = DW'($urandom);
      end
      return r;
   endfunction

   task automatic csr_write(input logic [IW-1:0] index,
                            input logic [RW-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (index)
         robb_pkg::CSR_BOX_CENTER:     box_regs.center     = data;
         robb_pkg::CSR_BOX_AXIS_U:     box_regs.axis[0]    = data;
         robb_pkg::CSR_BOX_AXIS_V:     box_regs.axis[1]    = data;
         robb_pkg::CSR_BOX_AXIS_W:     box_regs.axis[2]    = data;
         robb_pkg::CSR_BOX_HALF_SIZES: box_regs.half_sizes = data;
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (hit_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic set_box(input logic [RW-1:0] center, input logic [RW-1:0] u,
                          input logic [RW-1:0] v, input logic [RW-1:0] w,
                          input logic [RW-1:0] half_sizes);
      drain();
      csr_write(robb_pkg::CSR_BOX_CENTER, center);
      csr_write(robb_pkg::CSR_BOX_AXIS_U, u);
      csr_write(robb_pkg::CSR_BOX_AXIS_V, v);
      csr_write(robb_pkg::CSR_BOX_AXIS_W, w);
      csr_write(robb_pkg::CSR_BOX_HALF_SIZES, half_sizes);
   endtask

   task automatic send_ray(input ray_type r);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.origin_x <= r.origin[0];
      req_chan.origin_y <= r.origin[1];
      req_chan.origin_z <= r.origin[2];
      req_chan.dir_x    <= r.dir[0];
      req_chan.dir_y    <= r.dir[1];
      req_chan.dir_z    <= r.dir[2];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      hit_expected.push_back(ray_meets_box(r));
   endtask

   task automatic test_reset_box();
      send_ray(make_ray(0, 0, 0, 0, 0, 0));
      send_ray(make_ray(32767, -32768, POS_ONE, DIR_ONE, -DIR_ONE, 0));
      send_ray(random_ray());
   endtask

   task automatic test_unit_cube();
      set_box(pack3(0, 0, 0), pack3(DIR_ONE, 0, 0), pack3(0, DIR_ONE, 0),
              pack3(0, 0, DIR_ONE), pack3(POS_ONE, POS_ONE, POS_ONE));
      send_ray(make_ray(0, 0, 0, 0, 0, 0));
      send_ray(make_ray(POS_ONE, 0, 0, 0, 0, 0));
      send_ray(make_ray(2 * POS_ONE, 0, 0, 0, 0, 0));
      send_ray(make_ray(2 * POS_ONE, 0, 0, -DIR_ONE, 0, 0));
      send_ray(make_ray(2 * POS_ONE, 0, 0, DIR_ONE, 0, 0));
      send_ray(make_ray(2 * POS_ONE, 0, 0, 0, DIR_ONE, 0));
      send_ray(make_ray(2 * POS_ONE, 2 * POS_ONE, 0, -DIR_ONE, 0, 0));
      send_ray(make_ray(3 * POS_ONE, 3 * POS_ONE, 3 * POS_ONE, -9459, -9459, -9459));
      send_ray(make_ray(3 * POS_ONE, 0, 3 * POS_ONE, -DIR_ONE, DIR_ONE, 0));
      send_ray(make_ray(32767, 32767, 32767, -32768, -32768, -32768));
      send_ray(make_ray(-32768, -32768, -32768, 32767, 32767, 32767));
      send_ray(make_ray(0, 0, 0, -32768, 32767, -32768));
      // Writes to unused indexes must leave the box untouched.
      drain();
      for (int i = robb_pkg::CSR_BOX_HALF_SIZES + 1; i < (1 << IW); i++)
         csr_write(IW'(i), '1);
      send_ray(make_ray(2 * POS_ONE, 0, 0, 0, 0, 0));
   endtask

   task automatic test_extreme_boxes();
      set_box('1, '1, '1, '1, '1);
      send_ray(make_ray(0, 0, 0, 0, 0, 0));
      send_ray(make_ray(32767, 32767, 32767, -32768, -32768, -32768));
      send_ray(make_ray(-32768, -32768, -32768, 32767, 32767, 32767));
      send_ray(random_ray());
      set_box(pack3(32767, -32768, 32767), pack3(-32768, 32767, -32768),
              pack3(32767, -32768, 32767), pack3(-32768, -32768, 32767),
              pack3(0, 65535, 32768));
      send_ray(make_ray(32767, -32768, 32767, 0, 0, 0));
      send_ray(make_ray(-32768, 32767, -32768, 32767, -32768, 32767));
      send_ray(make_ray(0, 0, 0, -32768, 32767, -32768));
      send_ray(random_ray());
   endtask

   task automatic random_box();
      logic [RW-1:0] axis_reg [3];
      int            comp [3];
      int            kind;
      int            rot;
      int            flip;
      int            p;
      kind = $urandom_range(0, 2);
      rot  = $urandom_range(0, 2);
      flip = $urandom_range(0, 1);
      case (kind)
         0: begin
            // Axis-aligned box with permuted and mirrored axes.
            for (int k = 0; k < 3; k++) begin
               comp = '{0, 0, 0};
               p = (rot + (flip ? 3 - k : k)) % 3;
               comp[p] = $urandom_range(0, 1) ? DIR_ONE : -DIR_ONE;
               axis_reg[k] = pack3(comp[0], comp[1], comp[2]);
            end
         end
         1: begin
            axis_reg[0] = pack3(DIAG, DIAG, 0);
            axis_reg[1] = pack3(-DIAG, DIAG, 0);
            axis_reg[2] = pack3(0, 0, DIR_ONE);
         end
         default: begin
            for (int k = 0; k < 3; k++)
               axis_reg[k] = RW'({$urandom, $urandom});
         end
      endcase
      if (kind == 2)
         set_box(RW'({$urandom, $urandom}), axis_reg[0], axis_reg[1], axis_reg[2],
                 RW'({$urandom, $urandom}));
      else
         set_box(pack3($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                       $urandom_range(0, 4096) - 2048),
                 axis_reg[0], axis_reg[1], axis_reg[2],
                 pack3($urandom_range(0, 1024), $urandom_range(0, 1024),
                       $urandom_range(0, 1024)));
   endtask

   task automatic test_random_boxes();
      for (int b = 0; b < 10; b++) begin
         random_box();
         steady_flow = (b % 3 == 2);
         repeat (62) send_ray(random_ray());
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_output_stall();
      drain();
      steady_flow     = 1'b1;
      rsp_hold_cycles = 200;
      repeat (30) send_ray(random_ray());
      drain();
      repeat (20) send_ray(random_ray());
      steady_flow = 1'b0;
   endtask

   initial begin : rsp_side
      int stall;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = steady_flow ? 0 : $urandom_range(0, 15);
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (hit_expected.size() == 0) begin
            $error("hit: expected no response, actual %0b", rsp_chan.hit);
            fail_count++;
         end else begin
            want = hit_expected.pop_front();
            if (rsp_chan.hit !== want) begin
               $error("hit: expected %0b, actual %0b", want, rsp_chan.hit);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready))
            idle = 0;
         else
            idle++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.origin_x = '0;
      req_chan.origin_y = '0;
      req_chan.origin_z = '0;
      req_chan.dir_x    = '0;
      req_chan.dir_y    = '0;
      req_chan.dir_z    = '0;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = '0;
      csr_chan.data     = '0;
      box_regs          = '0;
      fail_count        = 0;
      steady_flow       = 1'b0;
      rsp_hold_cycles   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_box();
      test_unit_cube();
      test_extreme_boxes();
      test_random_boxes();
      test_output_stall();
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
design/robb_pkg.sv
design/robb_if.sv
design/robb_pipe.sv
design/ray_obb_overlap_test_top.sv
sim/tb.sv
